>>> hw/rtl/lcsp_pkg.sv
// shared constants and types for the lru cache with stride prefetch
package lcsp_pkg;

  localparam int MEM_WORDS  = 16384;
  localparam int ENTRIES    = 128;
  localparam int DEPTH      = 10;
  localparam int ADDR_W     = 14;
  localparam int DATA_W     = 16;
  localparam int AGE_W      = 32;
  localparam int STRIDE_W   = 15;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int PF_W       = $clog2(DEPTH + 1);
  localparam int BK_AW      = $clog2(MEM_WORDS);
  localparam int TGT_W      = 20;
  localparam int ADDR_LIMIT = 16384;

  localparam logic [1:0] KIND_READ     = 2'd0;
  localparam logic [1:0] KIND_PREFETCH = 2'd1;
  localparam logic [1:0] KIND_WRITE    = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // entry write port
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] tag;
    logic [AGE_W-1:0]  age;
    logic [DATA_W-1:0] data;
  } ent_wr_t;

  // outcome of one pass over the entries
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  found_idx;
    logic [DATA_W-1:0] found_data;
    logic [IDX_W-1:0]  victim;
  } scan_res_t;

endpackage

>>> hw/rtl/lcsp_scan.sv
// entry memory with one-entry-per-cycle tag search and victim pick (first invalid entry, else lru)
module lcsp_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lcsp_pkg::ADDR_W-1:0] tgt,
  input  lcsp_pkg::ent_wr_t         wr,
  output logic                      done,
  output lcsp_pkg::scan_res_t       res
);
  import lcsp_pkg::*;

  localparam int ENT_W = ADDR_W + AGE_W + DATA_W;

  logic [ENT_W-1:0]  mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [ENT_W-1:0]  ent_q;
  logic [CNT_W-1:0]  sidx;
  logic [IDX_W-1:0]  ev_idx;
  logic              ev_on;
  logic              running;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [DATA_W-1:0] found_data;
  logic              inv_found;
  logic [IDX_W-1:0]  inv_idx;
  logic              min_set;
  logic [AGE_W-1:0]  min_age;
  logic [IDX_W-1:0]  min_idx;
  logic [ADDR_W-1:0] ev_tag;
  logic [AGE_W-1:0]  ev_age;
  logic [DATA_W-1:0] ev_data;
  logic              ev_valid;

  assign ev_tag   = ent_q[ENT_W-1 -: ADDR_W];
  assign ev_age   = ent_q[DATA_W +: AGE_W];
  assign ev_data  = ent_q[DATA_W-1:0];
  assign ev_valid = valid[ev_idx];
  assign done     = running && (sidx == CNT_W'(ENTRIES)) && !ev_on;

  always_comb begin
    res.found      = found;
    res.found_idx  = found_idx;
    res.found_data = found_data;
    res.victim     = inv_found ? inv_idx : min_idx;
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= {wr.tag, wr.age, wr.data};
    end
    if (running && (sidx != CNT_W'(ENTRIES))) begin
      ent_q <= mem[sidx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      running <= 1'b0;
      ev_on   <= 1'b0;
      sidx    <= '0;
    end else begin
      if (wr.en) begin
        valid[wr.idx] <= 1'b1;
      end
      if (start) begin
        running <= 1'b1;
        sidx    <= '0;
        ev_on   <= 1'b0;
      end else if (running) begin
        if (sidx != CNT_W'(ENTRIES)) begin
          ev_idx <= sidx[IDX_W-1:0];
          ev_on  <= 1'b1;
          sidx   <= sidx + 1'b1;
        end else begin
          ev_on <= 1'b0;
        end
        if (done) begin
          running <= 1'b0;
        end
      end
    end
  end

  // running search state, payload only
  always_ff @(posedge clk) begin
    if (start) begin
      found     <= 1'b0;
      inv_found <= 1'b0;
      min_set   <= 1'b0;
      min_idx   <= '0;
    end else if (ev_on) begin
      if (ev_valid && (ev_tag == tgt) && !found) begin
        found      <= 1'b1;
        found_idx  <= ev_idx;
        found_data <= ev_data;
      end
      if (!ev_valid && !inv_found) begin
        inv_found <= 1'b1;
        inv_idx   <= ev_idx;
      end
      if (ev_valid && (!min_set || (ev_age < min_age))) begin
        min_set <= 1'b1;
        min_age <= ev_age;
        min_idx <= ev_idx;
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !running) else $error("scan still running after done");
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    start |=> !ev_on && (sidx == '0)) else $error("scan not restarted");
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    running |-> !wr.en) else $error("entry written during search");

endmodule

>>> hw/rtl/lru_cache_with_stride_prefetch.sv
// top level: fully associative lru word cache with stride prefetch
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | opcode, address, write_value
//  output   | out_valid / out_stall| kind, hit, line_address, read_data, way,
//           |                      | last
//
// load: the write is taken when accepted, and its result is held and offered
//   from the finish state, which then returns to idle for the next input
// read: one entry search, then a decide and a finish state
// each prefetch target in range adds a step, a search and a decide, each
//   target out of range only a step, and the end of the walk another step;
//   each search walks one entry per cycle
// one item at a time: in_stall is high whenever an item is in progress
// reset clears valid bits, the age counter, stride and handshake state at once
// a result is held one step so its last flag is known; output stalls only
// hold the sequencer, never the stored state
module lru_cache_with_stride_prefetch (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [lcsp_pkg::ADDR_W-1:0]   address,
  input  logic [lcsp_pkg::DATA_W-1:0]   write_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    kind,
  output logic                          hit,
  output logic [lcsp_pkg::ADDR_W-1:0]   line_address,
  output logic [lcsp_pkg::DATA_W-1:0]   read_data,
  output logic [lcsp_pkg::IDX_W-1:0]    way,
  output logic                          last
);
  import lcsp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_PFNEXT = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]          state;
  logic                pf_mode;
  logic [ADDR_W-1:0]   tgt;
  logic [AGE_W-1:0]    age_counter;
  logic [STRIDE_W-1:0] stride;
  logic [ADDR_W-1:0]   previous_miss;
  logic                previous_valid;
  logic [PF_W-1:0]     pf_i;
  logic [TGT_W-1:0]    pf_t;
  logic [TGT_W-1:0]    pf_t_next;
  logic [STRIDE_W-1:0] miss_delta;
  logic                stride_match;
  logic                pf_in_range;
  logic                scan_start;
  logic                scan_done;
  scan_res_t           sres;
  ent_wr_t             ewr;
  logic                out_free;
  logic                go;
  logic                out_load;

  // held result, released once the next one or the end of the item is known
  logic                hold_valid;
  logic [1:0]          hold_kind;
  logic                hold_hit;
  logic [ADDR_W-1:0]   hold_addr;
  logic [DATA_W-1:0]   hold_data;
  logic [IDX_W-1:0]    hold_way;

  // backing memory, synchronous read
  logic [DATA_W-1:0]   bmem [MEM_WORDS];
  logic [DATA_W-1:0]   bk_q;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign go        = !hold_valid || out_free;
  assign miss_delta = STRIDE_W'({1'b0, tgt}) - STRIDE_W'({1'b0, previous_miss});
  assign stride_match = previous_valid && (miss_delta == stride);
  assign pf_t_next = pf_t + {{(TGT_W-STRIDE_W){stride[STRIDE_W-1]}}, stride};
  assign pf_in_range = !pf_t_next[TGT_W-1]
                    && ($signed(pf_t_next) < $signed(TGT_W'(MEM_WORDS)))
                    && ($signed(pf_t_next) < $signed(TGT_W'(ADDR_LIMIT)));

  // output register takes a new result: the held one moves out on a new
  // result, or the final one moves out at the end of the item
  assign out_load = ((state == S_DECIDE) && go && !(pf_mode && sres.found) && hold_valid)
                 || ((state == S_FINISH) && out_free);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && (opcode == OP_LOAD)
        && (({1'b0, address}) < (ADDR_W + 1)'(MEM_WORDS))) begin
      bmem[address[BK_AW-1:0]] <= write_value;
    end
    if (state == S_SCAN) begin
      bk_q <= bmem[tgt[BK_AW-1:0]];
    end
  end

  lcsp_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .tgt   (tgt),
    .wr    (ewr),
    .done  (scan_done),
    .res   (sres)
  );

  // entry write on a hit refresh or a fill
  always_comb begin
    ewr      = '0;
    ewr.tag  = tgt;
    ewr.age  = age_counter + 1'b1;
    ewr.idx  = sres.found ? sres.found_idx : sres.victim;
    ewr.data = sres.found ? sres.found_data : bk_q;
    if ((state == S_DECIDE) && go) begin
      ewr.en = !(pf_mode && sres.found);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      hold_valid     <= 1'b0;
      scan_start     <= 1'b0;
      age_counter    <= '0;
      stride         <= '0;
      previous_miss  <= '0;
      previous_valid <= 1'b0;
    end else begin
      // a search starts on an accepted read or on a prefetch target in range
      scan_start <= ((state == S_IDLE) && in_valid && (opcode == OP_READ))
                 || ((state == S_PFNEXT) && (pf_i != PF_W'(DEPTH)) && pf_in_range);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tgt     <= address;
            pf_mode <= 1'b0;
            if (opcode == OP_LOAD) begin
              hold_valid <= 1'b1;
              hold_kind  <= KIND_WRITE;
              hold_hit   <= 1'b0;
              hold_addr  <= address;
              hold_data  <= '0;
              hold_way   <= '0;
              state      <= S_FINISH;
            end else begin
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (go) begin
            if (!(pf_mode && sres.found)) begin
              if (hold_valid) begin
                kind         <= hold_kind;
                hit          <= hold_hit;
                line_address <= hold_addr;
                read_data    <= hold_data;
                way          <= hold_way;
                last         <= 1'b0;
              end
              age_counter <= age_counter + 1'b1;
              hold_valid  <= 1'b1;
              hold_kind   <= pf_mode ? KIND_PREFETCH : KIND_READ;
              hold_hit    <= sres.found;
              hold_addr   <= tgt;
              hold_data   <= pf_mode ? '0 : ewr.data;
              hold_way    <= ewr.idx;
            end
            if (pf_mode) begin
              state <= S_PFNEXT;
            end else if (sres.found) begin
              state <= S_FINISH;
            end else begin
              previous_miss  <= tgt;
              previous_valid <= 1'b1;
              if (previous_valid && !stride_match) begin
                stride <= miss_delta;
              end
              pf_i    <= '0;
              pf_t    <= TGT_W'(tgt);
              pf_mode <= 1'b1;
              state   <= stride_match ? S_PFNEXT : S_FINISH;
            end
          end
        end
        S_PFNEXT: begin
          if (pf_i == PF_W'(DEPTH)) begin
            state <= S_FINISH;
          end else begin
            pf_i <= pf_i + 1'b1;
            pf_t <= pf_t_next;
            if (pf_in_range) begin
              tgt        <= pf_t_next[ADDR_W-1:0];
              state      <= S_SCAN;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            kind         <= hold_kind;
            hit          <= hold_hit;
            line_address <= hold_addr;
            read_data    <= hold_data;
            way          <= hold_way;
            last         <= 1'b1;
            hold_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind != 2'd3)) else $error("illegal result kind");
  a_write_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_WRITE)) |-> last) else $error("write ack not last");
  a_finish_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> hold_valid) else $error("finish with nothing held");

endmodule
